// ===== rtl/stack_machine_execute_unit_assert.svh =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_assert
// Assertion macros shared by the stack machine execute unit: implication
// checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smx assertion failed");
`define SMX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smx assertion failed");
`else
`define SMX_ASSERT_IMP(label, ante, cons)
`define SMX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/smx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Sizes, opcodes, status codes and the controller/datapath interface types
// of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int WORD_W         = 32;
   localparam int OPC_W          = 5;
   localparam int STAT_W         = 3;
   localparam int KIND_W         = 2;
   localparam int DATA_DEPTH     = 64;
   localparam int DS_AW          = $clog2(DATA_DEPTH);
   localparam int CNT_W          = $clog2(DATA_DEPTH + 1);
   localparam int CELL_COUNT     = 1024;
   localparam int CELL_AW        = $clog2(CELL_COUNT);
   localparam int LOOP_DEPTH     = 16;
   localparam int LP_AW          = $clog2(LOOP_DEPTH);
   localparam int LP_CW          = $clog2(LOOP_DEPTH + 1);
   localparam int CALL_DEPTH     = 32;
   localparam int CL_AW          = $clog2(CALL_DEPTH);
   localparam int CL_CW          = $clog2(CALL_DEPTH + 1);
   localparam int PROGRAM_LENGTH = 16384;
   localparam int POS_W          = $clog2(PROGRAM_LENGTH);
   localparam int DIV_CW         = $clog2(WORD_W);

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT,
      OP_LT, OP_AND, OP_OR, OP_XOR, OP_INVERT, OP_DUP, OP_DROP, OP_SWAP,
      OP_OVER, OP_ROT, OP_PRINT, OP_FETCH, OP_STORE, OP_ADDSTORE, OP_CLEARCELL,
      OP_DO, OP_LOOP, OP_INDEX, OP_LEAVE, OP_CALL, OP_RETURN, OP_IFBRANCH,
      OP_PRINTCELL, OP_EMIT
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK, ST_UNDERFLOW, ST_OVERFLOW, ST_DIVZERO, ST_BADADDR, ST_LOOPERR,
      ST_CALLERR
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      PK_NONE, PK_NUMBER, PK_CHAR
   } print_kind_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic [1:0] rd_off;
      logic       cap_b;
      logic       cap_a;
      logic       cap_c;
      logic       exec;
      logic       div_fin;
      logic       wr_go;
      logic [1:0] wr_idx;
      logic       clr_go;
   } smx_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_done;
      logic       div_op;
      logic       div_done;
      logic [1:0] wr_cnt;
   } smx_stat_type;

endpackage
`default_nettype wire

// ===== rtl/smx_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smx_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module smx_div import smx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output logic                   done,
   output logic [WORD_W-1:0]      quotient,
   output logic [WORD_W-1:0]      remainder
);

   logic              busy_ff, done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [WORD_W-1:0] rem_ff, quo_ff, den_ff;
   logic              negq_ff, negr_ff;
   logic [WORD_W-1:0] dvd_mag, dvs_mag;
   logic [WORD_W:0]   trial;

   assign dvd_mag = dividend[WORD_W-1] ? WORD_W'(0) - dividend : dividend;
   assign dvs_mag = divisor[WORD_W-1]  ? WORD_W'(0) - divisor  : divisor;
   assign trial   = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(WORD_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dvd_mag;
         den_ff  <= dvs_mag;
         negq_ff <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
         negr_ff <= dividend[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_ff <= trial[WORD_W-1:0];
            quo_ff <= {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? WORD_W'(0) - quo_ff : quo_ff;
   assign remainder = negr_ff ? WORD_W'(0) - rem_ff : rem_ff;

endmodule
`default_nettype wire

// ===== rtl/smx_dpath.sv =====
`default_nettype none
`include "stack_machine_execute_unit_assert.svh"
// ----------------------------------------------------------------------------
// smx_dpath
// Datapath: data stack and cell memories, loop and call stacks, operand
// registers, operation decode and result registers.
// ----------------------------------------------------------------------------
module smx_dpath import smx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [OPC_W-1:0]  req_opcode,
   input  wire logic [WORD_W-1:0] req_literal,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire smx_cmd_type       cmd,
   output smx_stat_type           stat,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [KIND_W-1:0]      rsp_print_kind,
   output logic [WORD_W-1:0]      rsp_print_value,
   output logic                   rsp_branch_taken,
   output logic [POS_W-1:0]       rsp_branch_target,
   output logic [WORD_W-1:0]      rsp_top_value,
   output logic [CNT_W-1:0]       rsp_stack_depth
);

   opcode_type        op_ff;
   logic [WORD_W-1:0] lit_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  dcnt_ff;
   logic [LP_CW-1:0]  lc_ff;
   logic [CL_CW-1:0]  cc_ff;
   logic [CELL_AW-1:0] clr_ptr_ff;

   logic [WORD_W-1:0] dstk_mem [DATA_DEPTH];
   logic [WORD_W-1:0] cell_mem [CELL_COUNT];
   logic [WORD_W-1:0] rd_q_ff, cell_q_ff, opa_ff, opb_ff, opc_ff;

   logic [WORD_W-1:0] lp_idx_ff [LOOP_DEPTH];
   logic [WORD_W-1:0] lp_lim_ff [LOOP_DEPTH];
   logic [POS_W-1:0]  lp_ret_ff [LOOP_DEPTH];
   logic [POS_W-1:0]  cl_ret_ff [CALL_DEPTH];

   logic [DS_AW-1:0]  wr_addr_ff [3];
   logic [WORD_W-1:0] wr_data_ff [3];
   logic [1:0]        wr_cnt_ff;

   logic [STAT_W-1:0] st_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [WORD_W-1:0] pval_ff, top_ff;
   logic              taken_ff;
   logic [POS_W-1:0]  target_ff;

   logic [CNT_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  cm1, cm2, cm3;
   logic [LP_CW-1:0]  lcm1;
   logic [CL_CW-1:0]  ccm1;
   logic [WORD_W-1:0] lp_cur, lp_lim, lp_next;
   logic [POS_W-1:0]  lp_ret, cl_ret;
   logic [WORD_W-1:0] mul_lo, top_old, top_d1, top_d2, div_res;
   logic              full, b_bad, lit_cbad, lit_pbad, lp_less;
   logic              div_done;
   logic [WORD_W-1:0] div_quo, div_rem;

   status_type        st;
   print_kind_type    kind;
   logic [WORD_W-1:0] pval, top_n, r;
   logic              taken;
   logic [POS_W-1:0]  target;
   logic [CNT_W-1:0]  new_c;
   logic [1:0]        wcnt;
   logic [DS_AW-1:0]  wa0, wa1, wa2;
   logic [WORD_W-1:0] wd0, wd1, wd2;
   logic              cell_we;
   logic [CELL_AW-1:0] cell_wa;
   logic [WORD_W-1:0] cell_wd;
   logic              lp_push, lp_pop, lp_upd, cl_push, cl_pop, div_op;

   assign rd_addr = dcnt_ff - CNT_W'(cmd.rd_off);
   assign cm1     = dcnt_ff - CNT_W'(1);
   assign cm2     = dcnt_ff - CNT_W'(2);
   assign cm3     = dcnt_ff - CNT_W'(3);
   assign lcm1    = lc_ff - LP_CW'(1);
   assign ccm1    = cc_ff - CL_CW'(1);
   assign lp_cur  = lp_idx_ff[lcm1[LP_AW-1:0]];
   assign lp_lim  = lp_lim_ff[lcm1[LP_AW-1:0]];
   assign lp_ret  = lp_ret_ff[lcm1[LP_AW-1:0]];
   assign cl_ret  = cl_ret_ff[ccm1[CL_AW-1:0]];
   assign lp_next = lp_cur + WORD_W'(1);
   assign lp_less = $signed(lp_next) < $signed(lp_lim);
   assign mul_lo  = opa_ff * opb_ff;
   assign full    = dcnt_ff >= CNT_W'(DATA_DEPTH);
   assign b_bad   = opb_ff >= WORD_W'(CELL_COUNT);
   assign lit_cbad = lit_ff >= WORD_W'(CELL_COUNT);
   assign lit_pbad = lit_ff >= WORD_W'(PROGRAM_LENGTH);
   assign top_old = (dcnt_ff != '0) ? opb_ff : '0;
   assign top_d1  = (dcnt_ff >= CNT_W'(2)) ? opa_ff : '0;
   assign top_d2  = (dcnt_ff >= CNT_W'(3)) ? opc_ff : '0;
   assign div_res = (op_ff == OP_MOD) ? div_rem : div_quo;

   smx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.exec & div_op),
      .dividend  (opa_ff),
      .divisor   (opb_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      st = ST_OK; kind = PK_NONE; pval = '0; taken = 1'b0; target = '0;
      new_c = dcnt_ff; top_n = top_old; r = '0;
      wcnt = 2'd0; wa0 = cm1[DS_AW-1:0]; wa1 = cm2[DS_AW-1:0]; wa2 = cm3[DS_AW-1:0];
      wd0 = '0; wd1 = '0; wd2 = '0;
      cell_we = 1'b0; cell_wa = opb_ff[CELL_AW-1:0]; cell_wd = opa_ff;
      lp_push = 1'b0; lp_pop = 1'b0; lp_upd = 1'b0;
      cl_push = 1'b0; cl_pop = 1'b0; div_op = 1'b0;
      case (op_ff)
         OP_PUSH: begin
            if (full) st = ST_OVERFLOW;
            else begin
               wcnt = 2'd1; wa0 = dcnt_ff[DS_AW-1:0]; wd0 = lit_ff;
               new_c = dcnt_ff + CNT_W'(1); top_n = lit_ff;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT, OP_LT,
         OP_AND, OP_OR, OP_XOR: begin
            case (op_ff)
               OP_ADD:  r = opa_ff + opb_ff;
               OP_SUB:  r = opa_ff - opb_ff;
               OP_MUL:  r = mul_lo;
               OP_EQ:   r = (opa_ff == opb_ff) ? '1 : '0;
               OP_GT:   r = ($signed(opb_ff) < $signed(opa_ff)) ? '1 : '0;
               OP_LT:   r = ($signed(opa_ff) < $signed(opb_ff)) ? '1 : '0;
               OP_AND:  r = opa_ff & opb_ff;
               OP_OR:   r = opa_ff | opb_ff;
               OP_XOR:  r = opa_ff ^ opb_ff;
               default: r = '0;
            endcase
            if (dcnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
            else if ((op_ff == OP_DIV || op_ff == OP_MOD) && opb_ff == '0) st = ST_DIVZERO;
            else begin
               div_op = (op_ff == OP_DIV || op_ff == OP_MOD);
               wcnt = 2'd1; wa0 = cm2[DS_AW-1:0]; wd0 = r;
               new_c = cm1; top_n = r;
            end
         end
         OP_INVERT: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else begin
               wcnt = 2'd1; wd0 = ~opb_ff; top_n = ~opb_ff;
            end
         end
         OP_DUP: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else if (full) st = ST_OVERFLOW;
            else begin
               wcnt = 2'd1; wa0 = dcnt_ff[DS_AW-1:0]; wd0 = opb_ff;
               new_c = dcnt_ff + CNT_W'(1); top_n = opb_ff;
            end
         end
         OP_DROP: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else begin
               new_c = cm1; top_n = top_d1;
            end
         end
         OP_SWAP: begin
            if (dcnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
            else begin
               wcnt = 2'd2; wd0 = opa_ff; wd1 = opb_ff; top_n = opa_ff;
            end
         end
         OP_OVER: begin
            if (dcnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
            else if (full) st = ST_OVERFLOW;
            else begin
               wcnt = 2'd1; wa0 = dcnt_ff[DS_AW-1:0]; wd0 = opa_ff;
               new_c = dcnt_ff + CNT_W'(1); top_n = opa_ff;
            end
         end
         OP_ROT: begin
            // ( a b c -- b c a )
            if (dcnt_ff < CNT_W'(3)) st = ST_UNDERFLOW;
            else begin
               wcnt = 2'd3; wd0 = opc_ff; wd1 = opb_ff; wd2 = opa_ff; top_n = opc_ff;
            end
         end
         OP_PRINT: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else begin
               kind = PK_NUMBER; pval = opb_ff; new_c = cm1; top_n = top_d1;
            end
         end
         OP_FETCH: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else if (b_bad) st = ST_BADADDR;
            else begin
               wcnt = 2'd1; wd0 = cell_q_ff; top_n = cell_q_ff;
            end
         end
         OP_PRINTCELL: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else if (b_bad) st = ST_BADADDR;
            else begin
               kind = PK_NUMBER; pval = cell_q_ff; new_c = cm1; top_n = top_d1;
            end
         end
         OP_STORE, OP_ADDSTORE: begin
            if (dcnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
            else if (b_bad) st = ST_BADADDR;
            else begin
               cell_we = 1'b1;
               cell_wd = (op_ff == OP_ADDSTORE) ? opa_ff + cell_q_ff : opa_ff;
               new_c = cm2; top_n = top_d2;
            end
         end
         OP_CLEARCELL: begin
            if (lit_cbad) st = ST_BADADDR;
            else begin
               cell_we = 1'b1; cell_wa = lit_ff[CELL_AW-1:0]; cell_wd = '0;
            end
         end
         OP_DO: begin
            if (dcnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
            else if (lc_ff >= LP_CW'(LOOP_DEPTH)) st = ST_LOOPERR;
            else begin
               lp_push = 1'b1; new_c = cm2; top_n = top_d2;
            end
         end
         OP_LOOP: begin
            if (lc_ff == '0) st = ST_LOOPERR;
            else if (lp_less) begin
               lp_upd = 1'b1; taken = 1'b1; target = lp_ret;
            end else lp_pop = 1'b1;
         end
         OP_INDEX: begin
            if (lc_ff == '0) st = ST_LOOPERR;
            else if (full) st = ST_OVERFLOW;
            else begin
               wcnt = 2'd1; wa0 = dcnt_ff[DS_AW-1:0]; wd0 = lp_cur;
               new_c = dcnt_ff + CNT_W'(1); top_n = lp_cur;
            end
         end
         OP_LEAVE: begin
            if (lc_ff == '0) st = ST_LOOPERR;
            else lp_pop = 1'b1;
         end
         OP_CALL: begin
            if (lit_pbad) st = ST_BADADDR;
            else if (cc_ff >= CL_CW'(CALL_DEPTH)) st = ST_CALLERR;
            else begin
               cl_push = 1'b1; taken = 1'b1; target = lit_ff[POS_W-1:0];
            end
         end
         OP_RETURN: begin
            if (cc_ff == '0) st = ST_CALLERR;
            else begin
               cl_pop = 1'b1; taken = 1'b1; target = cl_ret;
            end
         end
         OP_IFBRANCH: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else if (lit_pbad) st = ST_BADADDR;
            else begin
               taken = (opb_ff == '0);
               target = taken ? lit_ff[POS_W-1:0] : '0;
               new_c = cm1; top_n = top_d1;
            end
         end
         OP_EMIT: begin
            if (dcnt_ff == '0) st = ST_UNDERFLOW;
            else begin
               kind = PK_CHAR; pval = {{(WORD_W-8){1'b0}}, opb_ff[7:0]};
               new_c = cm1; top_n = top_d1;
            end
         end
         default: st = ST_OK;
      endcase
   end

   // control state: data stack depth, loop and call stack counters, clearing sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff    <= '0;
         lc_ff      <= '0;
         cc_ff      <= '0;
         clr_ptr_ff <= '0;
      end else begin
         if (cmd.clr_go) clr_ptr_ff <= clr_ptr_ff + CELL_AW'(1);
         if (cmd.exec) begin
            dcnt_ff <= new_c;
            if (lp_push) lc_ff <= lc_ff + LP_CW'(1);
            else if (lp_pop) lc_ff <= lcm1;
            if (cl_push) cc_ff <= cc_ff + CL_CW'(1);
            else if (cl_pop) cc_ff <= ccm1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode_type'(req_opcode);
         lit_ff <= req_literal;
         pos_ff <= req_position;
      end
      rd_q_ff <= dstk_mem[rd_addr[DS_AW-1:0]];
      if (cmd.cap_b) opb_ff <= rd_q_ff;
      if (cmd.cap_a) opa_ff <= rd_q_ff;
      if (cmd.cap_c) opc_ff <= rd_q_ff;
      if (cmd.wr_go) dstk_mem[wr_addr_ff[cmd.wr_idx]] <= wr_data_ff[cmd.wr_idx];
      if (cmd.exec) begin
         st_ff         <= st;
         kind_ff       <= kind;
         pval_ff       <= pval;
         taken_ff      <= taken;
         target_ff     <= target;
         top_ff        <= top_n;
         wr_cnt_ff     <= wcnt;
         wr_addr_ff[0] <= wa0;
         wr_addr_ff[1] <= wa1;
         wr_addr_ff[2] <= wa2;
         wr_data_ff[0] <= wd0;
         wr_data_ff[1] <= wd1;
         wr_data_ff[2] <= wd2;
         if (lp_push) begin
            lp_idx_ff[lc_ff[LP_AW-1:0]] <= opb_ff;
            lp_lim_ff[lc_ff[LP_AW-1:0]] <= opa_ff;
            lp_ret_ff[lc_ff[LP_AW-1:0]] <= pos_ff;
         end
         if (lp_upd) lp_idx_ff[lcm1[LP_AW-1:0]] <= lp_next;
         if (cl_push) cl_ret_ff[cc_ff[CL_AW-1:0]] <= pos_ff;
      end
      if (cmd.div_fin) begin
         wr_data_ff[0] <= div_res;
         top_ff        <= div_res;
      end
   end

   // cell memory: one write port shared with the clearing sweep
   always_ff @(posedge clock) begin
      if (cmd.clr_go) cell_mem[clr_ptr_ff] <= '0;
      else if (cmd.exec && cell_we) cell_mem[cell_wa] <= cell_wd;
      if (cmd.cap_a) cell_q_ff <= cell_mem[opb_ff[CELL_AW-1:0]];
   end

   assign stat.clr_done = (clr_ptr_ff == CELL_AW'(CELL_COUNT - 1));
   assign stat.div_op   = div_op;
   assign stat.div_done = div_done;
   assign stat.wr_cnt   = wr_cnt_ff;

   assign rsp_status        = st_ff;
   assign rsp_print_kind    = kind_ff;
   assign rsp_print_value   = pval_ff;
   assign rsp_branch_taken  = taken_ff;
   assign rsp_branch_target = target_ff;
   assign rsp_top_value     = top_ff;
   assign rsp_stack_depth   = dcnt_ff;

   `SMX_ASSERT_IMP(a_dcnt_bound, 1'b1, dcnt_ff <= CNT_W'(DATA_DEPTH))
   `SMX_ASSERT_IMP(a_lc_bound, 1'b1, lc_ff <= LP_CW'(LOOP_DEPTH))
   `SMX_ASSERT_NEXT(a_err_keeps_depth, cmd.exec && st != ST_OK, $stable(dcnt_ff))

endmodule
`default_nettype wire

// ===== rtl/smx_ctrl.sv =====
`default_nettype none
`include "stack_machine_execute_unit_assert.svh"
// ----------------------------------------------------------------------------
// smx_ctrl
// Controller: sequences the cell clearing sweep, operand reads, execute,
// divider wait, stack writes and the result handshake.
// ----------------------------------------------------------------------------
module smx_ctrl import smx_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   input  wire smx_stat_type stat,
   output smx_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_DIVW, S_WR, S_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] wr_idx_ff, wr_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         wr_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_off = 2'd1;
      state_in   = state_ff;
      wr_idx_in  = wr_idx_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_go = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            // top of stack read is issued while waiting
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.cap_b  = 1'b1;
            cmd.rd_off = 2'd2;
            state_in   = S_RD2;
         end
         S_RD2: begin
            cmd.cap_a  = 1'b1;
            cmd.rd_off = 2'd3;
            state_in   = S_RD3;
         end
         S_RD3: begin
            cmd.cap_c = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec  = 1'b1;
            wr_idx_in = '0;
            state_in  = stat.div_op ? S_DIVW : S_WR;
         end
         S_DIVW: begin
            if (stat.div_done) begin
               cmd.div_fin = 1'b1;
               state_in    = S_WR;
            end
         end
         S_WR: begin
            if (stat.wr_cnt == 2'd0) state_in = S_RESP;
            else begin
               cmd.wr_go  = 1'b1;
               cmd.wr_idx = wr_idx_ff;
               wr_idx_in  = wr_idx_ff + 2'd1;
               if (2'(wr_idx_ff + 2'd1) == stat.wr_cnt) state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `SMX_ASSERT_IMP(a_div_done_in_wait, stat.div_done, state_ff == S_DIVW)
   `SMX_ASSERT_NEXT(a_accept_starts_read, req_valid && !req_stall, state_ff == S_RD1)
   `SMX_ASSERT_IMP(a_wr_idx_bound, state_ff == S_WR && stat.wr_cnt != 2'd0, wr_idx_ff < stat.wr_cnt)

endmodule
`default_nettype wire

// ===== rtl/stack_machine_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one decoded stack machine operation per transaction and returns
// one result transaction with status, print request and branch decision.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   opcode, literal, position
//  rsp_      out        rsp_valid/rsp_stall   status, print, branch, top, depth
//
//  each transaction runs three data stack reads, execute, up to three
//  data stack writes one at a time on the stack memory write port, result state.
//  div and mod also wait for the bit-serial divider.
//  after reset the cell memory is swept clear, all CELL_COUNT (1024) cells,
//  with req_stall high.
//  req_stall stays high until the result transaction has been taken.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit import smx_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OPC_W-1:0]         req_opcode,
   input  wire logic signed [WORD_W-1:0] req_literal,
   input  wire logic [POS_W-1:0]         req_position,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STAT_W-1:0]             rsp_status,
   output logic [KIND_W-1:0]             rsp_print_kind,
   output logic signed [WORD_W-1:0]      rsp_print_value,
   output logic                          rsp_branch_taken,
   output logic [POS_W-1:0]              rsp_branch_target,
   output logic signed [WORD_W-1:0]      rsp_top_value,
   output logic [CNT_W-1:0]              rsp_stack_depth
);

   smx_cmd_type       cmd;
   smx_stat_type      stat;
   logic [WORD_W-1:0] pval, top;

   smx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   smx_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_literal       (req_literal),
      .req_position      (req_position),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_print_kind    (rsp_print_kind),
      .rsp_print_value   (pval),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_branch_target (rsp_branch_target),
      .rsp_top_value     (top),
      .rsp_stack_depth   (rsp_stack_depth)
   );

   assign rsp_print_value = $signed(pval);
   assign rsp_top_value   = $signed(top);

endmodule
`default_nettype wire
